FILE: src/frmalloc_pkg.sv
// shared types, constants and codes of the frame allocator
`default_nettype none

package frmalloc_pkg;

	localparam int FRAMES   = 64;
	localparam int IDX_W    = 6;
	localparam int PAGE_W   = 20;
	localparam int CNT_W    = 7;
	localparam int SEED_W   = 32;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CNT_W-1:0]  FRAME_COUNT_RESET = CNT_W'(FRAMES);
	localparam logic [SEED_W-1:0] SEED_RESET        = SEED_W'(3);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_PIN   = 2'd1,
		OP_UNPIN = 2'd2,
		OP_FREE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ALL_PINNED = 2'd1,
		ST_MISMATCH   = 2'd2,
		ST_NOT_PINNED = 2'd3
	} status_t;

	typedef enum logic {
		REG_FRAME_COUNT = 1'b0,
		REG_RANDOM_SEED = 1'b1
	} reg_t;

	typedef struct packed {
		op_t               opcode;
		logic [PAGE_W-1:0] page_id;
		logic [IDX_W-1:0]  frame_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  result_frame;
		logic              evicted;
		logic [PAGE_W-1:0] evicted_page;
		status_t           status;
	} rsp_t;

	// remainder unit request and reply
	typedef struct packed {
		logic              start;
		logic [SEED_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [IDX_W-1:0] remainder;
	} rem_rsp_t;

	// generator control
	typedef struct packed {
		logic              load;
		logic [SEED_W-1:0] seed;
		logic              step;
	} rng_ctl_t;

endpackage

`default_nettype wire

FILE: src/frmalloc_rng.sv
// xorshift32 generator used to draw eviction candidates
`default_nettype none

module frmalloc_rng
	import frmalloc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rng_ctl_t          ctl,
	output logic [SEED_W-1:0]      next_value
);

	logic [SEED_W-1:0] state_q;
	logic [SEED_W-1:0] x1;
	logic [SEED_W-1:0] x2;

	always_comb begin
		x1         = state_q ^ (state_q << 13);
		x2         = x1 ^ (x1 >> 17);
		next_value = x2 ^ (x2 << 5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_RESET;
		end else if (ctl.load) begin
			// a zero seed would lock the generator at zero
			state_q <= (ctl.seed == '0) ? SEED_W'(1) : ctl.seed;
		end else if (ctl.step) begin
			state_q <= next_value;
		end
	end

endmodule

`default_nettype wire

FILE: src/frmalloc_rem.sv
// bit-serial remainder unit, one dividend bit per cycle
`default_nettype none

module frmalloc_rem
	import frmalloc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rem_req_t req,
	output rem_rsp_t      rsp
);

	localparam int STEPS  = SEED_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [STEP_W-1:0] cnt_q;
	logic [SEED_W-1:0] dvd_q;
	logic [IDX_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              done_q;
	logic [CNT_W-1:0]  trial;
	logic [CNT_W-1:0]  diff;

	always_comb begin
		trial = {rem_q, dvd_q[SEED_W-1]};
		diff  = (trial >= div_q) ? (trial - div_q) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1));
			if (req.start) begin
				cnt_q <= STEP_W'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[IDX_W-1:0];
		end
	end

	assign rsp.busy      = (cnt_q != '0);
	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

FILE: src/frame_allocator_random_evict.sv
// frame table with first-free allocation and random eviction
//
// usage: an item on the req channel (req_valid, req_stall, req_data) asks to
// allocate a frame for a page, or to pin, unpin or free one frame. each item
// gives exactly one item on the rsp channel (rsp_valid, rsp_stall, rsp_data)
// with the frame, eviction report and status.
// one item is worked on at a time: req_stall is high from acceptance until
// the result has moved into the output register.
// pin, unpin and free go through a check state, then to the output register.
// allocate scans the pinned and occupied marks one frame a cycle and stops
// at the first free frame. when every active frame is occupied, each random
// draw steps the generator, runs the bit-serial remainder unit over the drawn
// value, then reads the owner memory for a usable candidate.
// the expected draw count is active frames over unpinned active frames.
// if every active frame is pinned, allocate fails after the scan.
// reset clears all marks and loads the default frame count and seed; no
// clearing pass is needed. owner pages live in a single-port memory.
// a stalled result waits in the output register; the block accepts the
// next item meanwhile and holds its own result until the register frees up.
// configuration: frame_count at byte address 0, random_seed at 4; writing
// the seed reloads the generator at once.
`default_nettype none

module frame_allocator_random_evict
	import frmalloc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req_data,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp_data,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_DRAW  = 7'b0000100,
		S_MOD   = 7'b0001000,
		S_EVICT = 7'b0010000,
		S_CHECK = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [FRAMES-1:0] occ_q;
	logic [FRAMES-1:0] pin_q;
	req_t              cur_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  scan_q;
	logic              any_q;
	logic [IDX_W-1:0]  cand_q;
	rsp_t              res_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	// configuration registers
	logic [CNT_W-1:0]  frame_count_q;
	logic [SEED_W-1:0] seed_q;
	logic              cfg_wr;
	reg_t              cfg_reg;

	// owner memory
	logic [PAGE_W-1:0] owner_mem [FRAMES];
	logic [PAGE_W-1:0] owner_rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_addr;

	logic              accept;
	logic [CNT_W-1:0]  n_act;
	logic              scan_free;
	logic              scan_hit;
	logic              scan_last;
	logic              idx_in_range;
	logic              out_free;
	logic              cand_ok;

	rng_ctl_t          rng_ctl;
	logic [SEED_W-1:0] rng_next;
	rem_req_t          rem_req;
	rem_rsp_t          rem_rsp;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_reg = reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			seed_q        <= SEED_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_reg)
				REG_FRAME_COUNT: frame_count_q <= pwdata[CNT_W-1:0];
				REG_RANDOM_SEED: seed_q        <= pwdata[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_reg)
			REG_FRAME_COUNT: prdata = APB_DW'(frame_count_q);
			REG_RANDOM_SEED: prdata = APB_DW'(seed_q);
			default:         prdata = '0;
		endcase
	end

	// out-of-range counts clamp to one and to the table size
	always_comb begin
		if (frame_count_q == '0) begin
			n_act = CNT_W'(1);
		end else if (frame_count_q > CNT_W'(FRAMES)) begin
			n_act = CNT_W'(FRAMES);
		end else begin
			n_act = frame_count_q;
		end
	end

	// ---------------- shared units ----------------
	assign rng_ctl.load = cfg_wr && (cfg_reg == REG_RANDOM_SEED);
	assign rng_ctl.seed = pwdata[SEED_W-1:0];
	assign rng_ctl.step = (state_q == S_DRAW);

	frmalloc_rng u_rng (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rng_ctl),
		.next_value (rng_next)
	);

	assign rem_req.start    = (state_q == S_DRAW);
	assign rem_req.dividend = rng_next;
	assign rem_req.divisor  = n_q;

	frmalloc_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// ---------------- sequencer decode ----------------
	assign req_stall    = (state_q != S_IDLE);
	assign accept       = req_valid && !req_stall;
	assign scan_free    = !pin_q[scan_q];
	assign scan_hit     = scan_free && !occ_q[scan_q];
	assign scan_last    = ({1'b0, scan_q} == (n_q - CNT_W'(1)));
	assign idx_in_range = ({1'b0, cur_q.frame_index} < n_q);
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign cand_ok      = rem_rsp.done && !pin_q[rem_rsp.remainder];

	// single port: reads on acceptance and on a usable candidate, writes on install
	assign mem_we = ((state_q == S_SCAN) && scan_hit) || (state_q == S_EVICT);
	assign mem_re = accept || ((state_q == S_MOD) && cand_ok);

	always_comb begin
		case (state_q)
			S_SCAN:  mem_addr = scan_q;
			S_MOD:   mem_addr = rem_rsp.remainder;
			S_EVICT: mem_addr = cand_q;
			default: mem_addr = req_data.frame_index;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			owner_mem[mem_addr] <= cur_q.page_id;
		end
		if (mem_re) begin
			owner_rd_q <= owner_mem[mem_addr];
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q   <= '0;
			pin_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req_data.opcode == OP_ALLOC) ? S_SCAN : S_CHECK;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						occ_q[scan_q] <= 1'b1;
						pin_q[scan_q] <= 1'b1;
						state_q       <= S_DONE;
					end else if (scan_last) begin
						state_q <= (any_q || scan_free) ? S_DRAW : S_DONE;
					end
				end
				S_DRAW: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (rem_rsp.done) begin
						state_q <= cand_ok ? S_EVICT : S_DRAW;
					end
				end
				S_EVICT: begin
					occ_q[cand_q] <= 1'b1;
					pin_q[cand_q] <= 1'b1;
					state_q       <= S_DONE;
				end
				S_CHECK: begin
					unique case (cur_q.opcode) inside
						OP_PIN: begin
							if (idx_in_range && occ_q[cur_q.frame_index]
								&& (owner_rd_q == cur_q.page_id)) begin
								pin_q[cur_q.frame_index] <= 1'b1;
							end
						end
						OP_UNPIN, OP_FREE: begin
							if (idx_in_range && pin_q[cur_q.frame_index]
								&& occ_q[cur_q.frame_index]) begin
								pin_q[cur_q.frame_index] <= 1'b0;
								if (cur_q.opcode == OP_FREE) begin
									occ_q[cur_q.frame_index] <= 1'b0;
								end
							end
						end
						default: ;
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and the result being built
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= req_data;
			n_q    <= n_act;
			scan_q <= '0;
			any_q  <= 1'b0;
		end
		case (state_q)
			S_SCAN: begin
				if (scan_free) begin
					any_q <= 1'b1;
				end
				if (!scan_last) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				res_q.result_frame <= scan_hit ? scan_q : '0;
				res_q.evicted      <= 1'b0;
				res_q.evicted_page <= '0;
				res_q.status       <= (scan_hit || any_q || scan_free) ? ST_OK : ST_ALL_PINNED;
			end
			S_MOD: begin
				cand_q <= rem_rsp.remainder;
			end
			S_EVICT: begin
				res_q.result_frame <= cand_q;
				res_q.evicted      <= 1'b1;
				res_q.evicted_page <= owner_rd_q;
				res_q.status       <= ST_OK;
			end
			S_CHECK: begin
				res_q.result_frame <= cur_q.frame_index;
				res_q.evicted      <= 1'b0;
				res_q.evicted_page <= '0;
				if (cur_q.opcode == OP_PIN) begin
					res_q.status <= (idx_in_range && occ_q[cur_q.frame_index]
						&& (owner_rd_q == cur_q.page_id)) ? ST_OK : ST_MISMATCH;
				end else begin
					res_q.status <= (idx_in_range && pin_q[cur_q.frame_index]
						&& occ_q[cur_q.frame_index]) ? ST_OK : ST_NOT_PINNED;
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rsp_data_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

`default_nettype wire

FILE: src/frmalloc_chk.sv
// port-level checks of the frame allocator, bound to the top level
`default_nettype none

module frmalloc_chk
	import frmalloc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp_data
);

	// one item in flight: the block stalls right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("no stall after item accepted");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled result changed");

	a_no_evict_page: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_data.evicted) |-> (rsp_data.evicted_page == '0))
		else $error("evicted page set without eviction");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status == ST_ALL_PINNED))
		|-> ((rsp_data.result_frame == '0) && !rsp_data.evicted))
		else $error("failed allocation reports a frame");

	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.evicted) |-> (rsp_data.status == ST_OK))
		else $error("eviction with error status");

endmodule

bind frame_allocator_random_evict frmalloc_chk u_frmalloc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the frame allocator with random eviction
module testbench;
	import frmalloc_pkg::*;

	// watchdog: the slowest legal run stays far below this
	localparam int unsigned WATCHDOG_CYCLES = 20_000_000;
	localparam int unsigned PHASES          = 10;
	localparam int unsigned PHASE_ITEMS     = 130;
	localparam int unsigned MAX_PRINTED     = 30;

	// block ports, every input known from time zero
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req_data  = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp_data;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [APB_AW-1:0]   paddr     = '0;
	logic [APB_DW-1:0]   pwdata    = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// shadow frame table, kept in step with every accepted item
	bit                  tbl_occupied [FRAMES];
	bit                  tbl_pinned   [FRAMES];
	bit [PAGE_W-1:0]     tbl_owner    [FRAMES];
	logic [SEED_W-1:0]   tbl_rng         = SEED_RESET;
	logic [SEED_W-1:0]   tbl_seed        = SEED_RESET;
	logic [CNT_W-1:0]    tbl_frame_count = FRAME_COUNT_RESET;

	// results still owed by the block, oldest first
	rsp_t                due_frame_results [$];

	// idling and hold-off control shared by sender and receiver
	bit                  idling    = 1'b1;
	int unsigned         hold_left = 0;
	int unsigned         stall_left = 0;

	// tallies for the closing summary
	int unsigned         error_count        = 0;
	int unsigned         items_accepted     = 0;
	int unsigned         results_checked    = 0;
	int unsigned         evictions_seen     = 0;
	int unsigned         all_pinned_seen    = 0;
	int unsigned         page_mismatch_seen = 0;
	int unsigned         not_pinned_seen    = 0;
	int unsigned         settings_used      = 0;

	logic [CNT_W-1:0]    phase_counts [PHASES] = '{
		7'd4, 7'd64, 7'd1, 7'd3, 7'd16, 7'd127, 7'd0, 7'd2, 7'd40, 7'd8
	};

	frame_allocator_random_evict u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial forever #6 clk = ~clk;

	// one line per mismatch, printing capped so a broken block stays readable
	task automatic flag_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("error: %s", what);
		error_count++;
	endtask

	// frame count as the block uses it: zero acts as one, too large as FRAMES
	function automatic int unsigned active_frames();
		if (tbl_frame_count == 0)
			return 1;
		if (tbl_frame_count > FRAMES)
			return FRAMES;
		return tbl_frame_count;
	endfunction

	// expected result of one item, updating the shadow table on the way
	function automatic rsp_t compute_frame_result(input req_t item);
		rsp_t        r;
		int unsigned n;
		int unsigned i;
		int unsigned c;
		bit          found;
		bit          any_unpinned;
		bit          in_range;
		r = '0;
		r.status = ST_OK;
		n = active_frames();
		found = 1'b0;
		any_unpinned = 1'b0;
		case (item.opcode)
			OP_ALLOC: begin
				// lowest frame that is neither pinned nor occupied
				for (i = 0; i < n; i++) begin
					if (!tbl_pinned[i]) begin
						any_unpinned = 1'b1;
						if (!tbl_occupied[i]) begin
							found = 1'b1;
							break;
						end
					end
				end
				if (found) begin
					r.result_frame = IDX_W'(i);
				end else if (!any_unpinned) begin
					r.status = ST_ALL_PINNED;
				end else begin
					// xorshift draws until an unpinned victim turns up
					do begin
						tbl_rng = tbl_rng ^ (tbl_rng << 13);
						tbl_rng = tbl_rng ^ (tbl_rng >> 17);
						tbl_rng = tbl_rng ^ (tbl_rng << 5);
						c = tbl_rng % n;
					end while (tbl_pinned[c]);
					r.result_frame = IDX_W'(c);
					r.evicted = 1'b1;
					r.evicted_page = tbl_owner[c];
					found = 1'b1;
				end
				if (found) begin
					tbl_occupied[r.result_frame] = 1'b1;
					tbl_pinned[r.result_frame] = 1'b1;
					tbl_owner[r.result_frame] = item.page_id;
				end
			end
			default: begin
				r.result_frame = item.frame_index;
				in_range = item.frame_index < n;
				if (item.opcode == OP_PIN) begin
					if (in_range && tbl_occupied[item.frame_index] &&
					    tbl_owner[item.frame_index] == item.page_id)
						tbl_pinned[item.frame_index] = 1'b1;
					else
						r.status = ST_MISMATCH;
				end else if (!(in_range && tbl_pinned[item.frame_index] &&
				               tbl_occupied[item.frame_index])) begin
					r.status = ST_NOT_PINNED;
				end else begin
					tbl_pinned[item.frame_index] = 1'b0;
					if (item.opcode == OP_FREE)
						tbl_occupied[item.frame_index] = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	// mostly well-formed traffic aimed at live frames, with some pure noise
	function automatic req_t pick_frame_item();
		req_t        item;
		int unsigned roll;
		int unsigned n;
		int unsigned i;
		int unsigned choices [$];
		item.opcode = op_t'($urandom_range(0, 3));
		item.page_id = PAGE_W'($urandom());
		item.frame_index = IDX_W'($urandom_range(0, FRAMES - 1));
		if ($urandom_range(0, 9) == 0)
			return item;
		n = active_frames();
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			item.opcode = OP_ALLOC;
		end else if (roll < 55) begin
			// pin a resident frame, usually with its own page
			item.opcode = OP_PIN;
			for (i = 0; i < n; i++)
				if (tbl_occupied[i])
					choices.push_back(i);
			if (choices.size() != 0) begin
				item.frame_index = IDX_W'(choices[$urandom_range(0, choices.size() - 1)]);
				if ($urandom_range(0, 4) != 0)
					item.page_id = tbl_owner[item.frame_index];
			end
		end else begin
			// release a frame that is actually pinned
			item.opcode = (roll < 80) ? OP_UNPIN : OP_FREE;
			for (i = 0; i < n; i++)
				if (tbl_pinned[i] && tbl_occupied[i])
					choices.push_back(i);
			if (choices.size() != 0)
				item.frame_index = IDX_W'(choices[$urandom_range(0, choices.size() - 1)]);
		end
		return item;
	endfunction

	// offer one item, hold it until taken, then book its expected result
	task automatic send_item(input req_t item);
		if (idling && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due_frame_results.push_back(compute_frame_result(item));
		items_accepted++;
	endtask

	task automatic send_op(input op_t op, input logic [PAGE_W-1:0] page,
	                       input logic [IDX_W-1:0] frame);
		req_t item;
		item.opcode = op;
		item.page_id = page;
		item.frame_index = frame;
		send_item(item);
	endtask

	// sender pauses until every owed result has come back
	task automatic wait_until_drained();
		req_valid <= 1'b0;
		while (due_frame_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb read, compared against the shadow register value
	task automatic check_register(input reg_t which);
		logic [APB_DW-1:0] want;
		want = (which == REG_FRAME_COUNT) ? APB_DW'(tbl_frame_count) : tbl_seed;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {which, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			flag_mismatch($sformatf("register %s reads %h, expected %h",
			                        which.name(), prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// apb write, then read back; a seed write reloads the generator at once
	task automatic set_register(input reg_t which, input logic [APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (which == REG_FRAME_COUNT) begin
			tbl_frame_count = value[CNT_W-1:0];
		end else begin
			tbl_seed = value;
			tbl_rng = (value == '0) ? SEED_W'(1) : value;
		end
		settings_used++;
		@(posedge clk);
		check_register(which);
	endtask

	// first-free allocation, repeated pin, wrong page, empty and unpinned frames
	task automatic test_basic_ops();
		send_op(OP_ALLOC, 20'h00000, 6'd0);
		send_op(OP_ALLOC, 20'hFFFFF, 6'd0);
		send_op(OP_PIN,   20'h00000, 6'd0);
		send_op(OP_PIN,   20'h12345, 6'd1);
		send_op(OP_PIN,   20'h00000, 6'd63);
		send_op(OP_UNPIN, 20'h00000, 6'd1);
		send_op(OP_UNPIN, 20'h00000, 6'd1);
		send_op(OP_FREE,  20'h00000, 6'd1);
		send_op(OP_PIN,   20'hFFFFF, 6'd1);
		send_op(OP_FREE,  20'hAAAAA, 6'd1);
		send_op(OP_FREE,  20'h55555, 6'd1);
		send_op(OP_UNPIN, 20'h00000, 6'd40);
	endtask

	// two frames: out-of-range index, table full of pins, then an eviction
	task automatic test_range_and_evict();
		wait_until_drained();
		set_register(REG_FRAME_COUNT, 32'd2);
		send_op(OP_PIN,   20'h00000, 6'd5);
		send_op(OP_UNPIN, 20'h00000, 6'd5);
		send_op(OP_FREE,  20'h00000, 6'd63);
		send_op(OP_ALLOC, 20'hABCDE, 6'd0);
		send_op(OP_ALLOC, 20'h00007, 6'd0);
		send_op(OP_UNPIN, 20'h00000, 6'd0);
		send_op(OP_ALLOC, 20'h55555, 6'd0);
	endtask

	// zero count acts as one frame, zero seed loads one, oversize count clamps
	task automatic test_count_extremes();
		wait_until_drained();
		set_register(REG_RANDOM_SEED, 32'd0);
		set_register(REG_FRAME_COUNT, 32'd0);
		send_op(OP_ALLOC, 20'h00001, 6'd0);
		send_op(OP_UNPIN, 20'h00000, 6'd0);
		send_op(OP_ALLOC, 20'h80000, 6'd0);
		wait_until_drained();
		set_register(REG_FRAME_COUNT, 32'd127);
		set_register(REG_RANDOM_SEED, 32'hFFFF_FFFF);
		send_op(OP_ALLOC, 20'h0F0F0, 6'd0);
		send_op(OP_PIN,   20'h00000, 6'd2);
	endtask

	// receiver holds off for a long stretch so the block backs up into its input
	task automatic test_output_hold();
		int unsigned k;
		wait_until_drained();
		idling = 1'b0;
		hold_left = 300;
		for (k = 0; k < 16; k++)
			send_item(pick_frame_item());
		wait_until_drained();
		idling = 1'b1;
	endtask

	// one setting of count and seed, random traffic with a full drain midway
	task automatic test_random_mix(input logic [CNT_W-1:0] count,
	                               input logic [SEED_W-1:0] seed, input bit with_idling);
		int unsigned k;
		wait_until_drained();
		set_register(REG_FRAME_COUNT, APB_DW'(count));
		set_register(REG_RANDOM_SEED, seed);
		idling = with_idling;
		for (k = 0; k < PHASE_ITEMS; k++) begin
			if (k == PHASE_ITEMS / 2)
				wait_until_drained();
			send_item(pick_frame_item());
		end
	endtask

	// receiver stall: long hold-off first, then random bursts, but only while idling is set
	always @(posedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!idling) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			rsp_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// every accepted result against the oldest owed one, field by field
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
			if (due_frame_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result frame %0d status %0d",
				                        rsp_data.result_frame, rsp_data.status));
			end else begin
				want = due_frame_results.pop_front();
				if (rsp_data.result_frame !== want.result_frame ||
				    rsp_data.evicted !== want.evicted ||
				    rsp_data.evicted_page !== want.evicted_page ||
				    rsp_data.status !== want.status)
					flag_mismatch($sformatf(
						"result %0d: frame %0d ev %0b page %h st %0d, want %0d %0b %h %0d",
						results_checked, rsp_data.result_frame, rsp_data.evicted,
						rsp_data.evicted_page, rsp_data.status, want.result_frame,
						want.evicted, want.evicted_page, want.status));
				results_checked++;
				if (want.evicted)
					evictions_seen++;
				case (want.status)
					ST_ALL_PINNED: all_pinned_seen++;
					ST_MISMATCH:   page_mismatch_seen++;
					ST_NOT_PINNED: not_pinned_seen++;
					default: ;
				endcase
			end
		end
	end

	// main sequence
	initial begin
		int unsigned p;
		logic [SEED_W-1:0] seed;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values of both registers
		check_register(REG_FRAME_COUNT);
		check_register(REG_RANDOM_SEED);
		test_basic_ops();
		test_range_and_evict();
		test_count_extremes();
		test_output_hold();
		// random phases; every third without idling, the last one quiet
		for (p = 0; p < PHASES; p++) begin
			if (p == 6)
				seed = '0;
			else if (p == 5)
				seed = 32'hFFFF_FFFF;
			else
				seed = $urandom();
			test_random_mix(phase_counts[p], seed, (p % 3 != 2) && (p != PHASES - 1));
		end
		wait_until_drained();
		repeat (40) @(posedge clk);
		$display("summary: %0d items in, %0d results checked over %0d register writes",
		         items_accepted, results_checked, settings_used);
		$display("summary: %0d evictions, %0d all-pinned, %0d page mismatch, %0d not pinned",
		         evictions_seen, all_pinned_seen, page_mismatch_seen, not_pinned_seen);
		if (error_count == 0 && due_frame_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("error: watchdog expired with %0d results owed", due_frame_results.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
src/frmalloc_pkg.sv
src/frmalloc_rng.sv
src/frmalloc_rem.sv
src/frame_allocator_random_evict.sv
src/frmalloc_chk.sv
tb/sv/testbench.sv
